### hw/rtl/pixel_pair_palette_builder_assert.svh
// Assertion macros shared by the palette builder RTL.
// In synthesis builds the macros expand to nothing.
`ifndef PIXEL_PAIR_PALETTE_BUILDER_ASSERT_SVH
`define PIXEL_PAIR_PALETTE_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define PPP_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("palette builder check failed");

// Antecedent in a cycle implies the consequent in the same cycle.
`define PPP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("palette builder check failed");

`else

`define PPP_ASSERT_HOLDS(lbl, cond)
`define PPP_ASSERT_IMPLIES(lbl, ante, cons)

`endif

`endif

### hw/rtl/ppp_pkg.sv
package ppp_pkg;

    localparam int DefCapacity = 32;

    localparam int ChanW   = 8;
    localparam int KeyW    = 12;
    localparam int PixW    = 6;
    localparam int IdxW    = 5;
    localparam int CntOutW = 6;
    localparam int OpW     = 2;
    localparam int StatW   = 3;

    localparam int InDataW  = 56;
    localparam int OutDataW = 24;

    localparam int QuantDiv = 85;

    // Request codes.
    localparam logic [OpW-1:0] OpInsert = 2'd0;
    localparam logic [OpW-1:0] OpLookup = 2'd1;
    localparam logic [OpW-1:0] OpRead   = 2'd2;

    // Result status codes.
    localparam logic [StatW-1:0] StOk      = 3'd0;
    localparam logic [StatW-1:0] StPresent = 3'd1;
    localparam logic [StatW-1:0] StAbsent  = 3'd2;
    localparam logic [StatW-1:0] StFull    = 3'd3;
    localparam logic [StatW-1:0] StRange   = 3'd4;

    // Control flags that travel with a request along the cell chain.
    typedef struct packed {
        logic           valid;
        logic [OpW-1:0] op;
        logic           done;   // sorted place of the key has been reached
        logic           found;  // key already held
        logic           shift;  // key placed, later entries move up
        logic           rhit;   // read index met an occupied cell
    } t_flags;

endpackage

### hw/rtl/ppp_quant.sv
module ppp_quant
    import ppp_pkg::*;
(
    input  logic [ChanW-1:0] i_red,
    input  logic [ChanW-1:0] i_green,
    input  logic [ChanW-1:0] i_blue,
    output logic [PixW-1:0]  o_pixel
);

    localparam logic [ChanW-1:0] Thr1 = ChanW'(QuantDiv);
    localparam logic [ChanW-1:0] Thr2 = ChanW'(2 * QuantDiv);

    // An 8-bit channel divided by 85 gives 0, 1, 2 or 3 (only 255 gives 3).
    function automatic logic [1:0] quant2(input logic [ChanW-1:0] x);
        logic [1:0] q;
        if (x == {ChanW{1'b1}}) begin
            q = 2'd3;
        end else if (x >= Thr2) begin
            q = 2'd2;
        end else if (x >= Thr1) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return q;
    endfunction

    assign o_pixel = {quant2(i_red), quant2(i_green), quant2(i_blue)};

endmodule

### hw/rtl/ppp_cell.sv
module ppp_cell
    import ppp_pkg::*;
#(
    parameter int CAPACITY = DefCapacity,
    parameter int CELL_IDX = 0,
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_flags          i_flags,
    input  logic [KeyW-1:0] i_key,
    input  logic [IdxW-1:0] i_idx,
    input  logic [CW-1:0]   i_count,
    input  logic [PW-1:0]   i_pos,
    input  logic [KeyW-1:0] i_carry,
    input  logic [KeyW-1:0] i_rdata,
    output t_flags          o_flags,
    output logic [KeyW-1:0] o_key,
    output logic [IdxW-1:0] o_idx,
    output logic [CW-1:0]   o_count,
    output logic [PW-1:0]   o_pos,
    output logic [KeyW-1:0] o_carry,
    output logic [KeyW-1:0] o_rdata
);

    localparam int XW = (CW > IdxW) ? CW : IdxW;

    logic [KeyW-1:0] r_entry;
    logic [KeyW-1:0] n_entry;
    t_flags          r_flags;
    t_flags          n_flags;
    logic [KeyW-1:0] r_key;
    logic [IdxW-1:0] r_idx;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    logic [KeyW-1:0] r_carry;
    logic [KeyW-1:0] n_carry;
    logic [KeyW-1:0] r_rdata;
    logic [KeyW-1:0] n_rdata;
    logic            w_occ;
    logic            w_sel;
    logic            w_room;

    assign w_occ  = i_count > CW'(CELL_IDX);
    assign w_room = i_count < CW'(CAPACITY);
    assign w_sel  = XW'(i_idx) == XW'(CELL_IDX);

    always_comb begin
        n_flags = i_flags;
        n_pos   = i_pos;
        n_carry = i_carry;
        n_rdata = i_rdata;
        n_entry = r_entry;
        if (i_flags.valid) begin
            if (i_flags.op == OpRead) begin
                if (w_sel && w_occ) begin
                    n_flags.rhit = 1'b1;
                    n_rdata      = r_entry;
                end
            end else if (!i_flags.done) begin
                // Move on while the held entry is smaller than the key.
                if (!(w_occ && (r_entry < i_key))) begin
                    n_flags.done = 1'b1;
                    n_pos        = PW'(CELL_IDX);
                    if (w_occ && (r_entry == i_key)) begin
                        n_flags.found = 1'b1;
                    end else if ((i_flags.op == OpInsert) && w_room) begin
                        n_flags.shift = 1'b1;
                        n_entry       = i_key;
                        n_carry       = r_entry;
                    end
                end
            end else if (i_flags.shift) begin
                n_entry = i_carry;
                n_carry = r_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
            r_key   <= i_key;
            r_idx   <= i_idx;
            r_count <= i_count;
            r_pos   <= n_pos;
            r_carry <= n_carry;
            r_rdata <= n_rdata;
        end
    end

    assign o_flags = r_flags;
    assign o_key   = r_key;
    assign o_idx   = r_idx;
    assign o_count = r_count;
    assign o_pos   = r_pos;
    assign o_carry = r_carry;
    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pixel_pair_palette_builder.sv
// A request accepted on the slave side walks every cell of the chain in turn and
// then the output register before its result beat shows on the master side.
// Only a single request is in the chain at a time: the next one may enter only
// after the current one has left the last cell for the output register.
// Reset: synchronous, active low; it empties the table (count zero), clears the
// overflow flag and drops any request in flight. Table contents need no reset.
`include "pixel_pair_palette_builder_assert.svh"

module pixel_pair_palette_builder
    import ppp_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata, low bit up: left_red[7:0], left_green[15:8], left_blue[23:16],
    // right_red[31:24], right_green[39:32], right_blue[47:40],
    // entry_index[52:48], zero padding[55:53].
    input  logic [InDataW-1:0]  s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [OpW-1:0]      s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata, low bit up: pair_index[4:0], entry_count[10:5], overflowed[11],
    // entry_left_pixel[17:12], entry_right_pixel[23:18].
    output logic [OutDataW-1:0] m_axis_tdata,
    // tuser: status[2:0].
    output logic [StatW-1:0]    m_axis_tuser
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // The table lives in a row of CAPACITY cells, one sorted entry in each.
    // A request walks the row one cell per cycle unless the chain is held. A lookup
    // or insert stops at the first cell that is empty or does not hold a smaller
    // key; an insert that does not meet its key there drops it into that cell if
    // the table has room, and the displaced entries ripple up one cell each cycle
    // behind it. A read picks up the entry of the cell whose position matches. The
    // beat that leaves the last cell is turned into the result and the count and
    // overflow flag are committed then, so the next request sees the new state.

    t_flags          w_flags [0:CAPACITY];
    logic [KeyW-1:0] w_key   [0:CAPACITY];
    logic [IdxW-1:0] w_idx   [0:CAPACITY];
    logic [CW-1:0]   w_count [0:CAPACITY];
    logic [PW-1:0]   w_pos   [0:CAPACITY];
    logic [KeyW-1:0] w_carry [0:CAPACITY];
    logic [KeyW-1:0] w_rdata [0:CAPACITY];
    logic [CAPACITY:0] w_valid_vec;

    logic [PixW-1:0] w_left_pix;
    logic [PixW-1:0] w_right_pix;

    logic            r_busy;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_overflow;
    logic            n_overflow;
    logic            r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic [StatW-1:0]    r_out_user;

    logic            w_accept;
    logic            w_xfer;
    logic            w_en;

    logic [StatW-1:0]    w_status;
    logic [IdxW-1:0]     w_pidx;
    logic [PixW-1:0]     w_eleft;
    logic [PixW-1:0]     w_eright;
    logic [PW+IdxW-1:0]  w_pos_ext;
    logic [CW+CntOutW-1:0] w_cnt_ext;

    // One request in the chain at a time.
    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ppp_quant u_quant_left (
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_pixel (w_left_pix)
    );

    ppp_quant u_quant_right (
        .i_red   (s_axis_tdata[31:24]),
        .i_green (s_axis_tdata[39:32]),
        .i_blue  (s_axis_tdata[47:40]),
        .o_pixel (w_right_pix)
    );

    // Head of the chain: the request as accepted, with the current count.
    always_comb begin
        w_flags[0]       = '0;
        w_flags[0].valid = w_accept;
        w_flags[0].op    = s_axis_tuser;
    end
    assign w_key[0]   = {w_left_pix, w_right_pix};
    assign w_idx[0]   = s_axis_tdata[52:48];
    assign w_count[0] = r_count;
    assign w_pos[0]   = '0;
    assign w_carry[0] = '0;
    assign w_rdata[0] = '0;

    // The chain holds while a finished beat at its end waits for the output
    // register to free up.
    assign w_xfer = w_flags[CAPACITY].valid && (!r_out_valid || m_axis_tready);
    assign w_en   = !(w_flags[CAPACITY].valid && !w_xfer);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ppp_cell #(
            .CAPACITY (CAPACITY),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_flags (w_flags[g]),
            .i_key   (w_key[g]),
            .i_idx   (w_idx[g]),
            .i_count (w_count[g]),
            .i_pos   (w_pos[g]),
            .i_carry (w_carry[g]),
            .i_rdata (w_rdata[g]),
            .o_flags (w_flags[g+1]),
            .o_key   (w_key[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_count (w_count[g+1]),
            .o_pos   (w_pos[g+1]),
            .o_carry (w_carry[g+1]),
            .o_rdata (w_rdata[g+1])
        );
    end

    for (genvar g = 0; g <= CAPACITY; g++) begin : g_valid
        assign w_valid_vec[g] = w_flags[g].valid;
    end

    assign w_pos_ext = {{IdxW{1'b0}}, w_pos[CAPACITY]};

    // Result of the beat leaving the last cell.
    always_comb begin
        w_status   = StOk;
        w_pidx     = '0;
        w_eleft    = '0;
        w_eright   = '0;
        n_count    = r_count;
        n_overflow = r_overflow;
        if (w_flags[CAPACITY].op == OpRead) begin
            if (w_flags[CAPACITY].rhit) begin
                w_pidx   = w_idx[CAPACITY];
                w_eleft  = w_rdata[CAPACITY][KeyW-1:PixW];
                w_eright = w_rdata[CAPACITY][PixW-1:0];
            end else begin
                w_status = StRange;
            end
        end else if (w_flags[CAPACITY].op == OpInsert) begin
            if (w_flags[CAPACITY].found) begin
                w_status = StPresent;
                w_pidx   = w_pos_ext[IdxW-1:0];
            end else if (w_flags[CAPACITY].shift) begin
                w_pidx  = w_pos_ext[IdxW-1:0];
                n_count = r_count + CW'(1);
            end else begin
                w_status   = StFull;
                n_overflow = 1'b1;
            end
        end else begin
            // Lookup; the spare request code behaves the same way.
            if (w_flags[CAPACITY].found) begin
                w_pidx = w_pos_ext[IdxW-1:0];
            end else begin
                w_status = StAbsent;
            end
        end
    end

    assign w_cnt_ext = {{CntOutW{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_xfer) begin
                r_busy <= 1'b0;
            end
            if (w_xfer) begin
                r_count     <= n_count;
                r_overflow  <= n_overflow;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_data <= {w_eright, w_eleft, n_overflow, w_cnt_ext[CntOutW-1:0], w_pidx};
            r_out_user <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // The table never holds more entries than it has cells.
    `PPP_ASSERT_HOLDS(a_count_bound, r_count <= CW'(CAPACITY))
    // The sticky overflow flag is only raised against a full table.
    `PPP_ASSERT_IMPLIES(a_overflow_full, r_overflow, r_count == CW'(CAPACITY))
    // At most one request walks the chain, and only while the block is busy.
    `PPP_ASSERT_HOLDS(a_single_request, $onehot0(w_valid_vec))
    `PPP_ASSERT_IMPLIES(a_exit_busy, w_flags[CAPACITY].valid, r_busy)

endmodule

### test/pixel_pair_palette_builder_test.sv
`timescale 1ns / 100ps

module pixel_pair_palette_builder_test;
    import ppp_pkg::*;

    // The package names three request codes; the fourth behaves as a lookup.
    localparam logic [OpW-1:0] OpSpare = 2'd3;

    // Cycles without a single beat on either side before the run is abandoned.
    localparam int StallLimit = 4000;
    // Cycles allowed for stray beats after the last expected result.
    localparam int DrainCycles = 48;
    localparam int RandomItems = 680;
    localparam int MaxPrinted = 40;

    typedef struct packed {
        logic [OpW-1:0]     op;
        logic [InDataW-1:0] data;
    } t_pair_request;

    typedef struct packed {
        logic [StatW-1:0]   status;
        logic [IdxW-1:0]    pair_index;
        logic [CntOutW-1:0] entry_count;
        logic               overflowed;
        logic [PixW-1:0]    left_pixel;
        logic [PixW-1:0]    right_pixel;
    } t_palette_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [OpW-1:0]      s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [StatW-1:0]    m_axis_tuser;

    t_pair_request   pending_requests[$];
    t_palette_result expected_results[$];

    // The predictor's own copy of the sorted table, its fill level and the
    // sticky overflow flag.
    logic [KeyW-1:0] held_keys[DefCapacity];
    int              held_count = 0;
    logic            overflow_seen = 1'b0;

    int   mismatches = 0;
    int   requests_taken = 0;
    int   idle_cycles = 0;
    logic request_beat = 1'b0;
    // While set, neither side inserts idle cycles.
    logic steady;

    pixel_pair_palette_builder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    assign steady = (requests_taken >= 250) && (requests_taken < 400);

    // Each channel falls into one of four levels by division by 85; a pixel
    // packs red, green and blue levels from the top down.
    function automatic logic [PixW-1:0] rgb222(input logic [7:0] red, input logic [7:0] green,
                                               input logic [7:0] blue);
        logic [7:0] rq;
        logic [7:0] gq;
        logic [7:0] bq;
        rq = red / 8'd85;
        gq = green / 8'd85;
        bq = blue / 8'd85;
        return {rq[1:0], gq[1:0], bq[1:0]};
    endfunction

    function automatic logic [KeyW-1:0] key_of(input logic [InDataW-1:0] data);
        return {rgb222(data[7:0], data[15:8], data[23:16]),
                rgb222(data[31:24], data[39:32], data[47:40])};
    endfunction

    // Walks the sorted table exactly as the block should and updates it.
    function automatic t_palette_result predict_palette_result(input logic [OpW-1:0] op,
                                                               input logic [InDataW-1:0] data);
        logic [KeyW-1:0] key;
        logic [IdxW-1:0] slot;
        int              pos;
        bit              hit;
        t_palette_result res;
        key  = key_of(data);
        slot = data[52:48];
        res  = '0;
        if (op == OpRead) begin
            if (slot < held_count) begin
                res.pair_index  = slot;
                res.left_pixel  = held_keys[slot][11:6];
                res.right_pixel = held_keys[slot][5:0];
            end else begin
                res.status = StRange;
            end
        end else begin
            pos = 0;
            while (pos < held_count && held_keys[pos] < key) pos++;
            hit = (pos < held_count) && (held_keys[pos] == key);
            if (op == OpInsert) begin
                if (hit) begin
                    res.status     = StPresent;
                    res.pair_index = IdxW'(pos);
                end else if (held_count >= DefCapacity) begin
                    res.status    = StFull;
                    overflow_seen = 1'b1;
                end else begin
                    for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i - 1];
                    held_keys[pos] = key;
                    held_count++;
                    res.status     = StOk;
                    res.pair_index = IdxW'(pos);
                end
            end else if (hit) begin
                // A lookup, whether by its own code or by the spare one.
                res.status     = StOk;
                res.pair_index = IdxW'(pos);
            end else begin
                res.status = StAbsent;
            end
        end
        res.entry_count = CntOutW'(held_count);
        res.overflowed  = overflow_seen;
        return res;
    endfunction

    function automatic logic [InDataW-1:0] pack_pair(input logic [7:0] lr, input logic [7:0] lg,
                                                     input logic [7:0] lb, input logic [7:0] rr,
                                                     input logic [7:0] rg, input logic [7:0] rb,
                                                     input logic [IdxW-1:0] slot);
        return {3'b000, slot, rb, rg, rr, lb, lg, lr};
    endfunction

    // Any byte that lands on the given level; the top level is reached by 255 alone.
    function automatic logic [7:0] byte_for_level(input logic [1:0] level);
        if (level == 2'd3) return 8'd255;
        return 8'(level * 85 + $urandom_range(0, 84));
    endfunction

    function automatic logic [InDataW-1:0] pair_from_key(input logic [KeyW-1:0] key,
                                                         input logic [IdxW-1:0] slot);
        return pack_pair(byte_for_level(key[11:10]), byte_for_level(key[9:8]),
                         byte_for_level(key[7:6]), byte_for_level(key[5:4]),
                         byte_for_level(key[3:2]), byte_for_level(key[1:0]), slot);
    endfunction

    task automatic queue_request(input logic [OpW-1:0] op, input logic [InDataW-1:0] data);
        t_pair_request rq;
        rq.op   = op;
        rq.data = data;
        pending_requests.push_back(rq);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    // Driver: a request beat stays on the bus until taken; a new one may follow
    // straight away or after a random idle cycle.
    always @(negedge i_clk) begin
        t_pair_request rq;
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || request_beat) begin
            if (pending_requests.size() > 0 && (steady || $urandom_range(0, 99) >= 15)) begin
                rq = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rq.data;
                s_axis_tuser  <= rq.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: result beats are checked first, then a request beat taken at the
    // same edge is run through the predictor. The watchdog lives here as well.
    always @(posedge i_clk) begin
        t_palette_result want;
        logic            taken;
        logic            shown;
        taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        shown = i_rst_n && m_axis_tvalid && m_axis_tready;
        request_beat <= taken;
        if (shown) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, status", m_axis_tuser, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[4:0] !== want.pair_index)
                    report_mismatch("pair_index", m_axis_tdata[4:0], want.pair_index);
                if (m_axis_tdata[10:5] !== want.entry_count)
                    report_mismatch("entry_count", m_axis_tdata[10:5], want.entry_count);
                if (m_axis_tdata[11] !== want.overflowed)
                    report_mismatch("overflowed", m_axis_tdata[11], want.overflowed);
                if (m_axis_tdata[17:12] !== want.left_pixel)
                    report_mismatch("entry_left_pixel", m_axis_tdata[17:12], want.left_pixel);
                if (m_axis_tdata[23:18] !== want.right_pixel)
                    report_mismatch("entry_right_pixel", m_axis_tdata[23:18], want.right_pixel);
            end
        end
        if (taken) begin
            expected_results.push_back(predict_palette_result(s_axis_tuser, s_axis_tdata));
            requests_taken <= requests_taken + 1;
        end
        if (taken || shown) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [KeyW-1:0]    keys_tried[$];
        logic [InDataW-1:0] data;
        logic [OpW-1:0]     op;
        int                 pick;
        int                 insert_share;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: an empty table first, then the channel boundaries.
        queue_request(OpRead,   pack_pair(0, 0, 0, 0, 0, 0, 5'd0));
        queue_request(OpLookup, pack_pair(0, 0, 0, 0, 0, 0, 5'd31));
        queue_request(OpSpare,  pack_pair(255, 255, 255, 255, 255, 255, 5'd0));
        queue_request(OpInsert, pack_pair(255, 255, 255, 255, 255, 255, 5'd31));
        queue_request(OpInsert, pack_pair(0, 0, 0, 0, 0, 0, 5'd0));
        queue_request(OpInsert, pack_pair(84, 85, 169, 170, 254, 255, 5'd0));
        // Same levels again from different bytes: already present.
        queue_request(OpInsert, pack_pair(0, 169, 85, 200, 170, 255, 5'd17));
        queue_request(OpInsert, pack_pair(255, 255, 255, 255, 255, 255, 5'd0));
        queue_request(OpLookup, pack_pair(50, 100, 150, 180, 220, 255, 5'd0));
        queue_request(OpSpare,  pack_pair(84, 84, 84, 84, 84, 84, 5'd10));
        queue_request(OpLookup, pack_pair(170, 170, 170, 85, 85, 85, 5'd0));
        queue_request(OpInsert, pack_pair(170, 170, 170, 85, 85, 85, 5'd0));
        queue_request(OpRead,   pack_pair(0, 0, 0, 0, 0, 0, 5'd0));
        queue_request(OpRead,   pack_pair(255, 255, 255, 255, 255, 255, 5'd1));
        queue_request(OpRead,   pack_pair(0, 0, 0, 0, 0, 0, 5'd3));
        queue_request(OpRead,   pack_pair(0, 0, 0, 0, 0, 0, 5'd4));
        queue_request(OpRead,   pack_pair(0, 0, 0, 0, 0, 0, 5'd31));
        queue_request(OpSpare,  pack_pair(170, 170, 170, 85, 85, 85, 5'd31));
        keys_tried.push_back(12'h000);
        keys_tried.push_back(12'hFFF);
        keys_tried.push_back(key_of(pack_pair(84, 85, 169, 170, 254, 255, 5'd0)));
        keys_tried.push_back(key_of(pack_pair(170, 170, 170, 85, 85, 85, 5'd0)));

        // The sender holds back here until every result of the opening is in.
        wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);

        // Inserts are kept rare at first so that the table fills slowly and
        // lookups and reads see many partial fills; later the table fills up
        // and stays full, so inserts of new pairs are dropped.
        for (int n = 0; n < RandomItems; n++) begin
            if (n == 340)
                wait (pending_requests.size() == 0 && !s_axis_tvalid &&
                      expected_results.size() == 0);
            insert_share = (n < 300) ? 10 : 30;
            pick = $urandom_range(0, 99);
            if (pick < insert_share)          op = OpInsert;
            else if (pick < insert_share + 40) op = OpLookup;
            else if (pick < insert_share + 46) op = OpSpare;
            else                               op = OpRead;
            if (keys_tried.size() > 0 && $urandom_range(0, 1) == 1) begin
                data = pair_from_key(keys_tried[$urandom_range(0, keys_tried.size() - 1)],
                                     5'($urandom_range(0, 31)));
            end else begin
                data = pack_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 5'($urandom_range(0, 31)));
                if (op == OpInsert) keys_tried.push_back(key_of(data));
            end
            queue_request(op, data);
        end

        wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
